// ===== rtl/smfp_pkg.sv =====
// shared types, phase codes and tag classification for the stack map frame parser
`default_nettype none
package smfp_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned ShortW = 16;
   localparam int unsigned PhaseW = 3;

   localparam logic [PhaseW-1:0] PH_TAG    = 3'd0;
   localparam logic [PhaseW-1:0] PH_OFF_HI = 3'd1;
   localparam logic [PhaseW-1:0] PH_OFF_LO = 3'd2;
   localparam logic [PhaseW-1:0] PH_VT_TAG = 3'd3;
   localparam logic [PhaseW-1:0] PH_VT_HI  = 3'd4;
   localparam logic [PhaseW-1:0] PH_VT_LO  = 3'd5;
   localparam logic [PhaseW-1:0] PH_CNT_HI = 3'd6;
   localparam logic [PhaseW-1:0] PH_CNT_LO = 3'd7;

   localparam logic [1:0] EV_HEADER = 2'd0;
   localparam logic [1:0] EV_COUNT  = 2'd1;
   localparam logic [1:0] EV_ENTRY  = 2'd2;
   localparam logic [1:0] EV_ERROR  = 2'd3;

   localparam logic [2:0] FK_SAME       = 3'd0;
   localparam logic [2:0] FK_LOCALS1    = 3'd1;
   localparam logic [2:0] FK_LOCALS1_EX = 3'd2;
   localparam logic [2:0] FK_CHOP       = 3'd3;
   localparam logic [2:0] FK_SAME_EX    = 3'd4;
   localparam logic [2:0] FK_APPEND     = 3'd5;
   localparam logic [2:0] FK_FULL       = 3'd6;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_RSVD_TAG = 2'd1;
   localparam logic [1:0] ERR_BAD_VT   = 2'd2;

   localparam logic [ByteW-1:0] TAG_SAME_MAX    = 8'd63;
   localparam logic [ByteW-1:0] TAG_LOCALS1_MAX = 8'd127;
   localparam logic [ByteW-1:0] TAG_RSVD_MAX    = 8'd246;
   localparam logic [ByteW-1:0] TAG_LOCALS1_EX  = 8'd247;
   localparam logic [ByteW-1:0] TAG_CHOP_MAX    = 8'd250;
   localparam logic [ByteW-1:0] TAG_SAME_EX     = 8'd251;
   localparam logic [ByteW-1:0] TAG_APPEND_MAX  = 8'd254;
   localparam logic [ByteW-1:0] TAG_FULL        = 8'd255;

   localparam logic [ByteW-1:0] VT_MAX    = 8'd8;
   localparam logic [ByteW-1:0] VT_OBJECT = 8'd7;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [ByteW-1:0]  tag;
      logic [ByteW-1:0]  hi_byte;
      logic [ShortW-1:0] offset;
      logic [ShortW-1:0] left;
      logic              stack;
      logic [3:0]        etype;
   } parse_state_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [2:0]        frame_kind;
      logic [ByteW-1:0]  frame_tag;
      logic [ShortW-1:0] frame_offset;
      logic              list_section;
      logic [ShortW-1:0] list_count;
      logic [3:0]        vtype;
      logic [ShortW-1:0] vtype_operand;
      logic [1:0]        error_code;
      logic              frame_done;
   } event_type;

   function automatic logic [2:0] kind_of(input logic [ByteW-1:0] t);
      logic [2:0] k;
      if (t <= TAG_SAME_MAX) k = FK_SAME;
      else if (t <= TAG_LOCALS1_MAX) k = FK_LOCALS1;
      else if (t <= TAG_RSVD_MAX) k = FK_SAME;
      else if (t == TAG_LOCALS1_EX) k = FK_LOCALS1_EX;
      else if (t <= TAG_CHOP_MAX) k = FK_CHOP;
      else if (t == TAG_SAME_EX) k = FK_SAME_EX;
      else if (t <= TAG_APPEND_MAX) k = FK_APPEND;
      else k = FK_FULL;
      return k;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/smfp_step.sv =====
// next-state and event logic for one byte of the stack map stream
`default_nettype none
module smfp_step (
   input  wire smfp_pkg::parse_state_type cur_state,
   input  wire [7:0]                      byte_in,
   output smfp_pkg::parse_state_type      nxt_state,
   output logic                           ev_valid,
   output smfp_pkg::event_type            ev
);
   import smfp_pkg::*;

   logic              do_finish;
   logic [3:0]        ent_vt;
   logic [ShortW-1:0] ent_op;
   logic [ShortW-1:0] word;
   logic [ShortW-1:0] left_m1;
   logic [ByteW-1:0]  append_n;

   assign word     = {cur_state.hi_byte, byte_in};
   assign left_m1  = cur_state.left - ShortW'(1);
   assign append_n = cur_state.tag - TAG_SAME_EX;

   always_comb begin
      nxt_state        = cur_state;
      ev_valid         = 1'b0;
      do_finish        = 1'b0;
      ent_vt           = '0;
      ent_op           = '0;
      ev.event_kind    = EV_HEADER;
      ev.frame_kind    = kind_of(cur_state.tag);
      ev.frame_tag     = cur_state.tag;
      ev.frame_offset  = cur_state.offset;
      ev.list_section  = 1'b0;
      ev.list_count    = '0;
      ev.vtype         = '0;
      ev.vtype_operand = '0;
      ev.error_code    = ERR_NONE;
      ev.frame_done    = 1'b0;

      case (cur_state.phase)
         PH_OFF_HI, PH_VT_HI, PH_CNT_HI: begin
            nxt_state.hi_byte = byte_in;
            nxt_state.phase   = cur_state.phase + PhaseW'(1);
         end
         PH_OFF_LO: begin
            nxt_state.offset = word;
            ev.frame_offset  = word;
            ev_valid         = 1'b1;
            if (cur_state.tag == TAG_LOCALS1_EX) begin
               nxt_state.left  = ShortW'(1);
               nxt_state.stack = 1'b1;
               nxt_state.phase = PH_VT_TAG;
            end else if (cur_state.tag <= TAG_SAME_EX) begin
               nxt_state.phase = PH_TAG;
               ev.frame_done   = 1'b1;
            end else if (cur_state.tag <= TAG_APPEND_MAX) begin
               nxt_state.left  = ShortW'(append_n);
               nxt_state.stack = 1'b0;
               nxt_state.phase = PH_VT_TAG;
            end else begin
               nxt_state.stack = 1'b0;
               nxt_state.phase = PH_CNT_HI;
            end
         end
         PH_CNT_LO: begin
            ev_valid      = 1'b1;
            ev.event_kind = EV_COUNT;
            if (word != '0) begin
               nxt_state.left  = word;
               nxt_state.phase = PH_VT_TAG;
               ev.list_section = cur_state.stack;
               ev.list_count   = word;
            end else if (!cur_state.stack) begin
               nxt_state.phase = PH_CNT_HI;
               nxt_state.stack = 1'b1;
            end else begin
               nxt_state.phase = PH_TAG;
               ev.list_section = 1'b1;
               ev.frame_done   = 1'b1;
            end
         end
         PH_VT_TAG: begin
            if (byte_in > VT_MAX) begin
               nxt_state.phase = PH_TAG;
               ev_valid        = 1'b1;
               ev.event_kind   = EV_ERROR;
               ev.list_section = cur_state.stack;
               ev.error_code   = ERR_BAD_VT;
               ev.frame_done   = 1'b1;
            end else begin
               nxt_state.etype = byte_in[3:0];
               if (byte_in >= VT_OBJECT) begin
                  nxt_state.phase = PH_VT_HI;
               end else begin
                  do_finish = 1'b1;
                  ent_vt    = byte_in[3:0];
               end
            end
         end
         PH_VT_LO: begin
            do_finish = 1'b1;
            ent_vt    = cur_state.etype;
            ent_op    = word;
         end
         default: begin
            nxt_state.tag    = byte_in;
            nxt_state.offset = '0;
            nxt_state.stack  = 1'b0;
            ev.frame_kind    = kind_of(byte_in);
            ev.frame_tag     = byte_in;
            ev.frame_offset  = '0;
            if (byte_in <= TAG_SAME_MAX) begin
               nxt_state.phase = PH_TAG;
               ev_valid        = 1'b1;
               ev.frame_done   = 1'b1;
            end else if (byte_in <= TAG_LOCALS1_MAX) begin
               nxt_state.left  = ShortW'(1);
               nxt_state.stack = 1'b1;
               nxt_state.phase = PH_VT_TAG;
               ev_valid        = 1'b1;
            end else if (byte_in <= TAG_RSVD_MAX) begin
               nxt_state.phase = PH_TAG;
               ev_valid        = 1'b1;
               ev.event_kind   = EV_ERROR;
               ev.error_code   = ERR_RSVD_TAG;
               ev.frame_done   = 1'b1;
            end else begin
               nxt_state.phase = PH_OFF_HI;
            end
         end
      endcase

      if (do_finish) begin
         nxt_state.left   = left_m1;
         ev_valid         = 1'b1;
         ev.event_kind    = EV_ENTRY;
         ev.vtype         = ent_vt;
         ev.vtype_operand = ent_op;
         ev.list_section  = cur_state.stack;
         if (left_m1 == '0) begin
            if (cur_state.tag == TAG_FULL && !cur_state.stack) begin
               nxt_state.stack = 1'b1;
               nxt_state.phase = PH_CNT_HI;
               ev.list_section = 1'b0;
            end else begin
               nxt_state.phase = PH_TAG;
               ev.frame_done   = 1'b1;
            end
         end else begin
            nxt_state.phase = PH_VT_TAG;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/stack_map_frame_parser.sv =====
// top level of the stack map frame parser: byte stream in, event stream out
//
//  channel | dir | payload
//  req_    | in  | tdata[7:0] byte_in
//  rsp_    | out | tdata frame fields, tuser event_kind, tlast frame_done
//
// one byte per cycle while rsp_ is not stalled; each event appears on rsp_ the cycle after its last byte
// the parser state and the output register are the only storage
// a byte is taken while the output register is empty or being drained
// bytes that finish no event only advance the parser state
// reset returns the parser to waiting for a frame tag and empties the output
`default_nettype none
module stack_map_frame_parser (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] byte_in
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [71:0] rsp_tdata,  // frame_kind, frame_tag, frame_offset, list_section,
                                   // list_count, vtype, vtype_operand, error_code, zero pad
   output logic [1:0] rsp_tuser,   // [1:0] event_kind
   output logic       rsp_tlast    // frame_done
);
   import smfp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   event_type       ev_ff;
   event_type       ev_in;
   logic            ev_valid_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   smfp_step u_step (
      .cur_state (state_ff),
      .byte_in   (req_tdata),
      .nxt_state (state_in),
      .ev_valid  (ev_valid_in),
      .ev        (ev_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_take && ev_valid_in) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && ev_valid_in) begin
         ev_ff <= ev_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = ev_ff.event_kind;
   assign rsp_tlast  = ev_ff.frame_done;
   assign rsp_tdata  = {6'd0, ev_ff.error_code, ev_ff.vtype_operand, ev_ff.vtype,
                        ev_ff.list_count, ev_ff.list_section, ev_ff.frame_offset,
                        ev_ff.frame_tag, ev_ff.frame_kind};

   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == EV_ERROR |-> rsp_tlast)
      else $error("error event without frame end");

   a_error_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((ev_ff.error_code != ERR_NONE) == (rsp_tuser == EV_ERROR)))
      else $error("error code disagrees with event kind");

   a_entries_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_VT_TAG || state_ff.phase == PH_VT_HI
      || state_ff.phase == PH_VT_LO |-> state_ff.left != '0)
      else $error("entry phase with no entries left");

   a_count_only_on_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_COUNT |-> ev_ff.list_count == '0)
      else $error("list count outside a count event");

   a_silent_byte_keeps_output: assert property (@(posedge clock) disable iff (reset)
      req_take && !ev_valid_in && !rsp_valid_ff |=> !rsp_tvalid)
      else $error("result produced by a byte that completes no event");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the stack map frame parser: byte stream in, event stream checked
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import smfp_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned OPENING_LEN = 30;
   localparam logic [OPENING_LEN*8-1:0] OPENING = {
      8'd0,
      8'd127, 8'd8, 8'hFF, 8'hFF,
      8'd128,
      8'd246,
      8'd247, 8'h00, 8'h01, 8'd7, 8'hAB, 8'hCD,
      8'd248, 8'hFF, 8'hFF,
      8'd251, 8'h12, 8'h34,
      8'd252, 8'h00, 8'h00, 8'd9,
      8'd255, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [7:0]  stream_bytes [$];
   event_type   events_due [$];
   int unsigned bytes_queued = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stalls_asked = 0;
   int unsigned stalls_done = 0;
   int unsigned hold_left = 0;

   // parser state as the predictor sees it
   logic [2:0]  stage = PH_TAG;
   logic [7:0]  cur_tag = '0;
   logic [7:0]  hi_acc = '0;
   logic [15:0] cur_offset = '0;
   logic [15:0] remaining = '0;
   logic        on_stack = 1'b0;
   logic [3:0]  pending_vt = '0;

   stack_map_frame_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [2:0] tag_class(input logic [7:0] t);
      if (t > TAG_APPEND_MAX) return FK_FULL;
      if (t > TAG_SAME_EX) return FK_APPEND;
      if (t == TAG_SAME_EX) return FK_SAME_EX;
      if (t > TAG_LOCALS1_EX) return FK_CHOP;
      if (t == TAG_LOCALS1_EX) return FK_LOCALS1_EX;
      if (t > TAG_LOCALS1_MAX) return FK_SAME;
      if (t > TAG_SAME_MAX) return FK_LOCALS1;
      return FK_SAME;
   endfunction

   function automatic event_type make_event(input logic [1:0] kind, input logic sec,
                                            input logic [15:0] cnt, input logic [3:0] vt,
                                            input logic [15:0] op, input logic [1:0] err,
                                            input logic done);
      event_type e;
      e.event_kind    = kind;
      e.frame_kind    = tag_class(cur_tag);
      e.frame_tag     = cur_tag;
      e.frame_offset  = cur_offset;
      e.list_section  = sec;
      e.list_count    = cnt;
      e.vtype         = vt;
      e.vtype_operand = op;
      e.error_code    = err;
      e.frame_done    = done;
      return e;
   endfunction

   // one verification entry finished: advance the list bookkeeping
   function automatic event_type close_entry(input logic [3:0] vt, input logic [15:0] op);
      logic sec;
      logic done;
      sec = on_stack;
      done = 1'b0;
      remaining = remaining - 16'd1;
      if (remaining != 0) begin
         stage = PH_VT_TAG;
      end else if (cur_tag == TAG_FULL && !on_stack) begin
         on_stack = 1'b1;
         stage = PH_CNT_HI;
         sec = 1'b0;
      end else begin
         done = 1'b1;
         stage = PH_TAG;
      end
      return make_event(EV_ENTRY, sec, 16'd0, vt, op, ERR_NONE, done);
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output event_type ev);
      logic [15:0] word;
      ev = '0;
      word = {hi_acc, b};
      case (stage)
         PH_OFF_HI, PH_VT_HI, PH_CNT_HI: begin
            hi_acc = b;
            stage = stage + 3'd1;
            return 1'b0;
         end
         PH_OFF_LO: begin
            cur_offset = word;
            if (cur_tag == TAG_LOCALS1_EX) begin
               remaining = 16'd1;
               on_stack = 1'b1;
               stage = PH_VT_TAG;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b0);
            end else if (cur_tag <= TAG_SAME_EX) begin
               stage = PH_TAG;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b1);
            end else if (cur_tag <= TAG_APPEND_MAX) begin
               remaining = 16'(cur_tag - TAG_SAME_EX);
               on_stack = 1'b0;
               stage = PH_VT_TAG;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b0);
            end else begin
               on_stack = 1'b0;
               stage = PH_CNT_HI;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b0);
            end
            return 1'b1;
         end
         PH_CNT_LO: begin
            if (word != 0) begin
               remaining = word;
               stage = PH_VT_TAG;
               ev = make_event(EV_COUNT, on_stack, word, 4'd0, 16'd0, ERR_NONE, 1'b0);
            end else if (!on_stack) begin
               stage = PH_CNT_HI;
               ev = make_event(EV_COUNT, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b0);
               on_stack = 1'b1;
            end else begin
               stage = PH_TAG;
               ev = make_event(EV_COUNT, 1'b1, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b1);
            end
            return 1'b1;
         end
         PH_VT_TAG: begin
            if (b > VT_MAX) begin
               stage = PH_TAG;
               ev = make_event(EV_ERROR, on_stack, 16'd0, 4'd0, 16'd0, ERR_BAD_VT, 1'b1);
               return 1'b1;
            end
            pending_vt = b[3:0];
            if (b >= VT_OBJECT) begin
               stage = PH_VT_HI;
               return 1'b0;
            end
            ev = close_entry(b[3:0], 16'd0);
            return 1'b1;
         end
         PH_VT_LO: begin
            ev = close_entry(pending_vt, word);
            return 1'b1;
         end
         default: begin
            cur_tag = b;
            cur_offset = '0;
            on_stack = 1'b0;
            if (b <= TAG_SAME_MAX) begin
               stage = PH_TAG;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b1);
               return 1'b1;
            end
            if (b <= TAG_LOCALS1_MAX) begin
               remaining = 16'd1;
               on_stack = 1'b1;
               stage = PH_VT_TAG;
               ev = make_event(EV_HEADER, 1'b0, 16'd0, 4'd0, 16'd0, ERR_NONE, 1'b0);
               return 1'b1;
            end
            if (b <= TAG_RSVD_MAX) begin
               stage = PH_TAG;
               ev = make_event(EV_ERROR, 1'b0, 16'd0, 4'd0, 16'd0, ERR_RSVD_TAG, 1'b1);
               return 1'b1;
            end
            stage = PH_OFF_HI;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void cmp_field(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count = error_count + 1;
      end
   endfunction

   function automatic void compare_event(input event_type want, input event_type got);
      cmp_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
      cmp_field("frame_kind", 16'(want.frame_kind), 16'(got.frame_kind));
      cmp_field("frame_tag", 16'(want.frame_tag), 16'(got.frame_tag));
      cmp_field("frame_offset", want.frame_offset, got.frame_offset);
      cmp_field("list_section", 16'(want.list_section), 16'(got.list_section));
      cmp_field("list_count", want.list_count, got.list_count);
      cmp_field("vtype", 16'(want.vtype), 16'(got.vtype));
      cmp_field("vtype_operand", want.vtype_operand, got.vtype_operand);
      cmp_field("error_code", 16'(want.error_code), 16'(got.error_code));
      cmp_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
      bytes_queued = bytes_queued + 1;
   endfunction

   function automatic void put_short(input logic [15:0] v);
      put_byte(v[15:8]);
      put_byte(v[7:0]);
   endfunction

   function automatic bit put_entry(input bit allow_bad);
      logic [7:0] vt;
      bit good;
      good = !allow_bad || ($urandom_range(29, 0) != 0);
      vt = good ? 8'($urandom_range(8, 0)) : 8'($urandom_range(255, 9));
      put_byte(vt);
      if (good && vt >= VT_OBJECT) put_short(16'($urandom_range(65535, 0)));
      return good;
   endfunction

   function automatic bit put_list(input int count, input bit allow_bad);
      put_short(16'(count));
      for (int i = 0; i < count; i++)
         if (!put_entry(allow_bad)) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void put_frame();
      int pick;
      logic [7:0] tag;
      pick = $urandom_range(99, 0);
      if (pick < 14) begin
         put_byte(8'($urandom_range(63, 0)));
      end else if (pick < 28) begin
         put_byte(8'($urandom_range(127, 64)));
         void'(put_entry(1'b1));
      end else if (pick < 38) begin
         put_byte(TAG_LOCALS1_EX);
         put_short(16'($urandom_range(65535, 0)));
         void'(put_entry(1'b1));
      end else if (pick < 48) begin
         put_byte(8'($urandom_range(250, 248)));
         put_short(16'($urandom_range(65535, 0)));
      end else if (pick < 56) begin
         put_byte(TAG_SAME_EX);
         put_short(16'($urandom_range(65535, 0)));
      end else if (pick < 72) begin
         tag = 8'($urandom_range(254, 252));
         put_byte(tag);
         put_short(16'($urandom_range(65535, 0)));
         for (int i = 0; i < int'(tag - TAG_SAME_EX); i++)
            if (!put_entry(1'b1)) return;
      end else if (pick < 94) begin
         put_byte(TAG_FULL);
         put_short(16'($urandom_range(65535, 0)));
         if (put_list($urandom_range(4, 0), 1'b1))
            void'(put_list($urandom_range(4, 0), 1'b1));
      end else begin
         put_byte(8'($urandom_range(246, 128)));
      end
   endfunction

   // mostly well-formed frames, some raw noise that knocks the parser off frame alignment
   function automatic void fill_to(input int unsigned target);
      int n;
      while (bytes_queued < target) begin
         if ($urandom_range(99, 0) < 90) begin
            put_frame();
         end else begin
            n = $urandom_range(6, 1);
            repeat (n) put_byte(8'($urandom_range(255, 0)));
         end
      end
   endfunction

   task automatic wait_quiet();
      while (stream_bytes.size() != 0 || req_tvalid) @(negedge clock);
      while (events_due.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (stream_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= stream_bytes.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver with random stalls and long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         stalls_done <= 0;
      end else if (stalls_done < stalls_asked) begin
         stalls_done <= stalls_done + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor: check results, then predict from accepted bytes
   always @(posedge clock) begin
      event_type got;
      event_type want;
      event_type ev;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.event_kind    = rsp_tuser;
            got.frame_kind    = rsp_tdata[2:0];
            got.frame_tag     = rsp_tdata[10:3];
            got.frame_offset  = rsp_tdata[26:11];
            got.list_section  = rsp_tdata[27];
            got.list_count    = rsp_tdata[43:28];
            got.vtype         = rsp_tdata[47:44];
            got.vtype_operand = rsp_tdata[63:48];
            got.error_code    = rsp_tdata[65:64];
            got.frame_done    = rsp_tlast;
            if (events_due.size() == 0) begin
               $error("event with nothing expected: event_kind %0d", rsp_tuser);
               error_count = error_count + 1;
            end else begin
               want = events_due.pop_front();
               compare_event(want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            if (parse_byte(req_tdata, ev)) events_due.insert(events_due.size(), ev);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      send_idle_pct = 28;
      recv_idle_pct = 80;
      for (int i = OPENING_LEN - 1; i >= 0; i--) put_byte(OPENING[i*8 +: 8]);
      fill_to(510);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      stalls_asked = 1;
      wait_quiet();

      send_idle_pct = 80;
      recv_idle_pct = 28;
      fill_to(1030);
      wait_quiet();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // full frame whose locals count needs the upper count byte
      put_byte(TAG_FULL);
      put_short(16'hFFFF);
      void'(put_list(257, 1'b0));
      void'(put_list(1, 1'b1));
      fill_to(1550);
      stalls_asked = 2;
      wait_quiet();
      repeat (10) @(negedge clock);

      if (events_due.size() != 0) begin
         $error("%0d expected events never arrived", events_due.size());
         error_count = error_count + 1;
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/smfp_pkg.sv
rtl/smfp_step.sv
rtl/stack_map_frame_parser.sv
tb/sv/tb_top.sv
